// File: rtl/lep_pkg.sv
package lep_pkg;

  // Default number of time bins taken per event before input is ignored.
  localparam int LEP_BIN_LIMIT = 1024;

  // Width of the reported bin number.
  localparam int LEP_BIN_NUM_W = 11;

  // Input item modes.
  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_EOF   = 2'd1;
  localparam logic [1:0] MODE_ABORT = 2'd2;

  // Result kinds.
  localparam logic [2:0] KIND_RECORD = 3'd0;
  localparam logic [2:0] KIND_BIN    = 3'd1;
  localparam logic [2:0] KIND_HCHAR  = 3'd2;
  localparam logic [2:0] KIND_HEND   = 3'd3;
  localparam logic [2:0] KIND_EVENT  = 3'd4;

  // Characters with a meaning in the event file.
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] text_byte;
  } lep_in_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic [14:0]              led_index;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [15:0]              records_so_far;
    logic [LEP_BIN_NUM_W-1:0] bin_number;
    logic [7:0]               header_char;
    logic                     last;
  } lep_res_t;

  // Results produced by one parsed item, pushed into the output queue together.
  typedef struct packed {
    logic [1:0] cnt;
    lep_res_t   r0;
    lep_res_t   r1;
  } lep_push_t;

endpackage

// File: rtl/lep_parser.sv
module lep_parser import lep_pkg::*; #(
  parameter int BIN_LIMIT = LEP_BIN_LIMIT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  lep_in_t   in_data,
  input  logic [7:0] bright_lim,
  input  logic      room_ok,
  output lep_push_t push
);

  localparam int BIN_W = $clog2(BIN_LIMIT + 1);

  // Input stage.
  logic    stg_valid_r;
  lep_in_t stg_data_r;
  logic    fire;

  // Line state.
  logic [7:0]  line_lead_r, line_lead_nxt;
  logic        line_has_r, line_has_nxt;
  logic        in_lead_r, in_lead_nxt;
  logic [14:0] val_sat_r, val_sat_nxt;
  logic [7:0]  val_low_r, val_low_nxt;

  // Event state.
  logic [1:0]       slot_r, slot_nxt;
  logic             header_on_r, header_on_nxt;
  logic [14:0]      held_led_r, held_led_nxt;
  logic [7:0]       held_red_r, held_red_nxt;
  logic [7:0]       held_green_r, held_green_nxt;
  logic [15:0]      rec_total_r, rec_total_nxt;
  logic [BIN_W-1:0] bin_total_r, bin_total_nxt;

  // Decode and datapath temporaries.
  logic [7:0]  c;
  logic        active;
  logic        do_close, do_take, do_event;
  logic        first;
  logic [7:0]  lead_t;
  logic        lead_digits;
  logic        c_dig;
  logic [3:0]  digit;
  logic [14:0] vs_base;
  logic [7:0]  vl_base;
  logic [18:0] vs_wide;
  logic [11:0] vl_wide;
  logic        lead_dig;
  logic        cl_valid;
  lep_res_t    cl_res;
  logic        hc_valid;
  lep_res_t    hc_res;
  lep_res_t    ev_res;

  function automatic logic [7:0] clamp(input logic [7:0] v, input logic [7:0] lim);
    clamp = (v < lim) ? v : lim;
  endfunction

  // The stage moves on when the output queue can take two results.
  assign fire     = stg_valid_r && room_ok;
  assign in_ready = !stg_valid_r || room_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_data_r <= in_data;
    end
  end

  // Per-character arithmetic for the leading digit run.
  assign c           = stg_data_r.text_byte;
  assign active      = bin_total_r < BIN_W'(BIN_LIMIT);
  assign first       = !line_has_r;
  assign lead_t      = first ? c : line_lead_r;
  assign lead_digits = first ? 1'b1 : in_lead_r;
  assign vs_base     = first ? 15'd0 : val_sat_r;
  assign vl_base     = first ? 8'd0 : val_low_r;
  assign digit       = 4'(c - 8'h30);
  assign vs_wide     = 19'(vs_base) * 19'd10 + 19'(digit);
  assign vl_wide     = 12'(vl_base) * 12'd10 + 12'(digit);

  always_comb begin
    c_dig    = c inside {[8'h30:8'h39]};
    lead_dig = line_lead_r inside {[8'h30:8'h39]};
  end

  // Dispatch on the mode of the staged item.
  always_comb begin
    do_close = 1'b0;
    do_take  = 1'b0;
    do_event = 1'b0;
    case (stg_data_r.mode)
      MODE_TEXT: begin
        if (active && c != CH_SPACE) begin
          if (c == CH_NL) begin
            do_close = 1'b1;
          end else begin
            do_take = 1'b1;
          end
        end
      end
      MODE_EOF: begin
        do_close = active && line_has_r;
        do_event = 1'b1;
      end
      MODE_ABORT: begin
        do_event = 1'b1;
      end
      default: begin
      end
    endcase
    if (!fire) begin
      do_close = 1'b0;
      do_take  = 1'b0;
      do_event = 1'b0;
    end
  end

  // Next state and results.
  always_comb begin
    line_lead_nxt  = line_lead_r;
    line_has_nxt   = line_has_r;
    in_lead_nxt    = in_lead_r;
    val_sat_nxt    = val_sat_r;
    val_low_nxt    = val_low_r;
    slot_nxt       = slot_r;
    header_on_nxt  = header_on_r;
    held_led_nxt   = held_led_r;
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    rec_total_nxt  = rec_total_r;
    bin_total_nxt  = bin_total_r;
    cl_valid       = 1'b0;
    cl_res         = '0;
    hc_valid       = 1'b0;
    hc_res         = '0;
    ev_res         = '0;
    ev_res.kind    = KIND_EVENT;
    ev_res.last    = 1'b1;
    push           = '0;

    // Closing a line: header toggle, header line end, bin end or a number field.
    if (do_close) begin
      if (line_has_r && line_lead_r == CH_Q) begin
        header_on_nxt = !header_on_r;
      end else if (header_on_r) begin
        cl_valid    = 1'b1;
        cl_res.kind = KIND_HEND;
      end else if (line_has_r && line_lead_r == CH_N) begin
        cl_valid              = 1'b1;
        cl_res.kind           = KIND_BIN;
        cl_res.records_so_far = rec_total_r;
        cl_res.bin_number     = LEP_BIN_NUM_W'(bin_total_r);
        bin_total_nxt         = bin_total_r + BIN_W'(1);
        slot_nxt              = 2'd0;
      end else if (line_has_r && lead_dig) begin
        case (slot_r)
          2'd0: begin
            held_led_nxt = val_sat_r;
            slot_nxt     = 2'd1;
          end
          2'd1: begin
            held_red_nxt = val_low_r;
            slot_nxt     = 2'd2;
          end
          2'd2: begin
            held_green_nxt = val_low_r;
            slot_nxt       = 2'd3;
          end
          default: begin
            cl_valid         = 1'b1;
            cl_res.kind      = KIND_RECORD;
            cl_res.led_index = held_led_r;
            cl_res.red       = clamp(held_red_r, bright_lim);
            cl_res.green     = clamp(held_green_r, bright_lim);
            cl_res.blue      = clamp(val_low_r, bright_lim);
            if (rec_total_r != 16'hFFFF) begin
              rec_total_nxt = rec_total_r + 16'd1;
            end
            slot_nxt = 2'd0;
          end
        endcase
      end
      line_lead_nxt = 8'd0;
      line_has_nxt  = 1'b0;
      in_lead_nxt   = 1'b0;
      val_sat_nxt   = 15'd0;
      val_low_nxt   = 8'd0;
    end

    // Taking an ordinary character into the current line.
    if (do_take) begin
      line_has_nxt  = 1'b1;
      line_lead_nxt = lead_t;
      in_lead_nxt   = lead_digits;
      val_sat_nxt   = vs_base;
      val_low_nxt   = vl_base;
      if (lead_digits) begin
        if (c_dig) begin
          val_sat_nxt = (vs_wide > 19'h7FFF) ? 15'h7FFF : vs_wide[14:0];
          val_low_nxt = vl_wide[7:0];
        end else begin
          in_lead_nxt = 1'b0;
        end
      end
      if (header_on_r && lead_t != CH_Q) begin
        hc_valid           = 1'b1;
        hc_res.kind        = KIND_HCHAR;
        hc_res.header_char = c;
      end
    end

    // End of file or abort clears the whole event.
    if (do_event) begin
      line_lead_nxt  = 8'd0;
      line_has_nxt   = 1'b0;
      in_lead_nxt    = 1'b0;
      val_sat_nxt    = 15'd0;
      val_low_nxt    = 8'd0;
      slot_nxt       = 2'd0;
      header_on_nxt  = 1'b0;
      held_led_nxt   = 15'd0;
      held_red_nxt   = 8'd0;
      held_green_nxt = 8'd0;
      rec_total_nxt  = 16'd0;
      bin_total_nxt  = '0;
    end

    // Order the results of this item.
    if (do_event) begin
      if (cl_valid) begin
        push.cnt = 2'd2;
        push.r0  = cl_res;
        push.r1  = ev_res;
      end else begin
        push.cnt = 2'd1;
        push.r0  = ev_res;
      end
    end else if (cl_valid) begin
      push.cnt     = 2'd1;
      push.r0      = cl_res;
      push.r0.last = 1'b1;
    end else if (hc_valid) begin
      push.cnt     = 2'd1;
      push.r0      = hc_res;
      push.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_lead_r  <= 8'd0;
      line_has_r   <= 1'b0;
      in_lead_r    <= 1'b0;
      val_sat_r    <= 15'd0;
      val_low_r    <= 8'd0;
      slot_r       <= 2'd0;
      header_on_r  <= 1'b0;
      held_led_r   <= 15'd0;
      held_red_r   <= 8'd0;
      held_green_r <= 8'd0;
      rec_total_r  <= 16'd0;
      bin_total_r  <= '0;
    end else begin
      line_lead_r  <= line_lead_nxt;
      line_has_r   <= line_has_nxt;
      in_lead_r    <= in_lead_nxt;
      val_sat_r    <= val_sat_nxt;
      val_low_r    <= val_low_nxt;
      slot_r       <= slot_nxt;
      header_on_r  <= header_on_nxt;
      held_led_r   <= held_led_nxt;
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      rec_total_r  <= rec_total_nxt;
      bin_total_r  <= bin_total_nxt;
    end
  end

  // The bin counter stops at the limit.
  a_bin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bin_total_r <= BIN_W'(BIN_LIMIT))
    else $error("bin counter passed the limit");

  // End of file and abort leave a clean event state behind.
  a_event_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (stg_data_r.mode == MODE_EOF || stg_data_r.mode == MODE_ABORT)
    |=> bin_total_r == '0 && !header_on_r && slot_r == 2'd0 && !line_has_r)
    else $error("event state not cleared");

  // Two results only come from a closed line followed by the event end.
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.r1.kind == KIND_EVENT && push.r1.last && !push.r0.last)
    else $error("bad result pair");

endmodule

// File: rtl/lep_out_fifo.sv
module lep_out_fifo import lep_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  lep_push_t push,
  output logic      room_ok,
  output logic      out_valid,
  input  logic      out_ready,
  output lep_res_t  out_data
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  lep_res_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             pop;

  // Room for a full pair of results.
  assign room_ok   = count_r <= (PTR_W + 1)'(DEPTH - 2);
  assign out_valid = count_r != '0;
  assign out_data  = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(push.cnt) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage writes, up to two entries per cycle.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PTR_W + 1)'(DEPTH))
    else $error("output queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room_ok)
    else $error("results pushed without room");

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3)
    else $error("more than two results for one item");

endmodule

// File: rtl/led_event_text_parser.sv
// Channel  | Ports                          | Transaction
// ---------+--------------------------------+----------------------------------
// input    | in_valid, in_ready, in_data    | one file byte, end of file or abort
// result   | out_valid, out_ready, out_data | one result item
// config   | cfg_we, cfg_wdata              | brightness limit write, no wait
//
// One input transaction is taken per cycle while the queue has room; it waits
// in the input stage register, and its results go into the output queue. An
// item that yields two results puts both in at once; the four-entry output
// queue lets input stay open while earlier results wait. The input stage
// stalls only when the queue has fewer than two free entries.
// Reset is synchronous, sets the brightness limit to 255 and clears all state.
module led_event_text_parser import lep_pkg::*; #(
  parameter int BIN_LIMIT = LEP_BIN_LIMIT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  lep_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output lep_res_t   out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic [7:0] bright_lim_r;
  logic       room_ok;
  lep_push_t  push;

  // Brightness limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_lim_r <= 8'hFF;
    end else if (cfg_we) begin
      bright_lim_r <= cfg_wdata;
    end
  end

  lep_parser #(
    .BIN_LIMIT (BIN_LIMIT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .bright_lim (bright_lim_r),
    .room_ok    (room_ok),
    .push       (push)
  );

  lep_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room_ok   (room_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lep_pkg::*;

  localparam int BIN_LIMIT = LEP_BIN_LIMIT;
  // Mode code that the parser has no use for.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Cycles allowed after the last result for items still inside the pipeline.
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 60;
  localparam int RANDOM_ITEMS = 175;

  typedef struct {
    lep_in_t  item;
    bit       typed;
    int       n_typed;
    lep_res_t typed_res;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lep_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lep_res_t out_data;
  logic     cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned limit_writes = 0;

  // Results still owed by the parser, oldest first.
  lep_res_t pending_results[$];
  // Results caused by the item just accepted.
  lep_res_t item_results[$];

  // Parser state as the testbench tracks it.
  logic [7:0]  bright_cap = 8'd255;
  logic [7:0]  line_first = '0;
  bit          line_open = 1'b0;
  bit          in_number = 1'b0;
  int unsigned num_sat = 0;
  logic [7:0]  num_low = '0;
  logic [1:0]  color_slot = '0;
  bit          header_mode = 1'b0;
  logic [14:0] pend_led = '0;
  logic [7:0]  pend_red = '0;
  logic [7:0]  pend_green = '0;
  int unsigned record_count = 0;
  int unsigned bin_count = 0;

  always #10 clk = ~clk;

  led_event_text_parser #(.BIN_LIMIT(BIN_LIMIT)) i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data,
    .cfg_we,
    .cfg_wdata
  );

  function automatic lep_res_t result_of(logic [2:0] kind, logic [14:0] led, logic [7:0] r,
                                         logic [7:0] g, logic [7:0] b, logic [15:0] recs,
                                         logic [10:0] bin, logic [7:0] ch);
    lep_res_t res;
    res.kind = kind;
    res.led_index = led;
    res.red = r;
    res.green = g;
    res.blue = b;
    res.records_so_far = recs;
    res.bin_number = bin;
    res.header_char = ch;
    res.last = 1'b0;
    return res;
  endfunction

  function automatic logic [7:0] clamp_to_cap(logic [7:0] v);
    return (v < bright_cap) ? v : bright_cap;
  endfunction

  function automatic bit is_decimal(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic void drop_line();
    line_first = '0;
    line_open = 1'b0;
    in_number = 1'b0;
    num_sat = 0;
    num_low = '0;
  endfunction

  function automatic void new_event();
    drop_line();
    color_slot = '0;
    header_mode = 1'b0;
    pend_led = '0;
    pend_red = '0;
    pend_green = '0;
    record_count = 0;
    bin_count = 0;
  endfunction

  // A closed line toggles header mode, ends a header line, ends a time bin
  // or feeds the next LED field.
  function automatic void finish_line();
    if (line_open && line_first == CH_Q) begin
      header_mode = !header_mode;
    end else if (header_mode) begin
      item_results.push_back(result_of(KIND_HEND, 0, 0, 0, 0, 0, 0, 0));
    end else if (line_open && line_first == CH_N) begin
      item_results.push_back(result_of(KIND_BIN, 0, 0, 0, 0, record_count[15:0],
                                       bin_count[10:0], 0));
      bin_count++;
      color_slot = 2'd0;
    end else if (line_open && is_decimal(line_first)) begin
      case (color_slot)
        2'd0: begin
          pend_led = num_sat[14:0];
          color_slot = 2'd1;
        end
        2'd1: begin
          pend_red = num_low;
          color_slot = 2'd2;
        end
        2'd2: begin
          pend_green = num_low;
          color_slot = 2'd3;
        end
        default: begin
          item_results.push_back(result_of(KIND_RECORD, pend_led, clamp_to_cap(pend_red),
                                           clamp_to_cap(pend_green), clamp_to_cap(num_low),
                                           0, 0, 0));
          if (record_count < 65535) record_count++;
          color_slot = 2'd0;
        end
      endcase
    end
    drop_line();
  endfunction

  // Leading digits build both the saturating index and the low color byte.
  function automatic void absorb_char(logic [7:0] c);
    int unsigned d;
    if (!line_open) begin
      line_open = 1'b1;
      line_first = c;
      in_number = 1'b1;
      num_sat = 0;
      num_low = '0;
    end
    if (in_number) begin
      if (is_decimal(c)) begin
        d = c - 8'h30;
        num_sat = num_sat * 10 + d;
        if (num_sat > 32767) num_sat = 32767;
        num_low = 8'((num_low * 10 + d) & 8'hFF);
      end else begin
        in_number = 1'b0;
      end
    end
  endfunction

  // Works out every result of one input transaction into item_results.
  function automatic void parse_item(lep_in_t it);
    logic [7:0] c;
    bit live;
    lep_res_t tail;
    c = it.text_byte;
    live = bin_count < BIN_LIMIT;
    item_results.delete();
    case (it.mode)
      MODE_TEXT: begin
        if (live && c != CH_SPACE) begin
          if (c == CH_NL) begin
            finish_line();
          end else begin
            absorb_char(c);
            if (header_mode && line_first != CH_Q)
              item_results.push_back(result_of(KIND_HCHAR, 0, 0, 0, 0, 0, 0, c));
          end
        end
      end
      MODE_EOF: begin
        if (live && line_open) finish_line();
        item_results.push_back(result_of(KIND_EVENT, 0, 0, 0, 0, 0, 0, 0));
        new_event();
      end
      MODE_ABORT: begin
        item_results.push_back(result_of(KIND_EVENT, 0, 0, 0, 0, 0, 0, 0));
        new_event();
      end
      default: ;
    endcase
    if (item_results.size() > 0) begin
      tail = item_results.pop_back();
      tail.last = 1'b1;
      item_results.push_back(tail);
    end
  endfunction

  function automatic lep_in_t mk_item(logic [1:0] m, logic [7:0] b);
    lep_in_t it;
    it.mode = m;
    it.text_byte = b;
    return it;
  endfunction

  function automatic stim_row_t txt(logic [7:0] c);
    stim_row_t r;
    r.item = mk_item(MODE_TEXT, c);
    r.typed = 1'b0;
    r.n_typed = 0;
    r.typed_res = '0;
    return r;
  endfunction

  function automatic logic [7:0] any_but_newline();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_NL);
    return b;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Offers one transaction, waits for it to be taken and records what it owes.
  task automatic send_item(lep_in_t it, bit typed, int n_typed, lep_res_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    parse_item(it);
    if (typed) begin
      if (n_typed != 0) pending_results.push_back(typed_res);
    end else begin
      foreach (item_results[j]) pending_results.push_back(item_results[j]);
    end
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(mk_item(MODE_TEXT, b), 1'b0, 0, '0);
  endtask

  task automatic send_marker(logic [1:0] m);
    send_item(mk_item(m, 8'($urandom_range(255))), 1'b0, 0, '0);
  endtask

  // Waits until every owed result has come out, then lets the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    bright_cap = v;
    limit_writes++;
  endtask

  // A decimal line, sometimes with a leading zero, spaces or trailing junk.
  task automatic send_number_line();
    string digits;
    int unsigned v;
    case ($urandom_range(3))
      0: v = $urandom_range(9);
      1: v = $urandom_range(255);
      2: v = $urandom_range(999);
      default: v = $urandom_range(99999);
    endcase
    digits = $sformatf("%0d", v);
    if ($urandom_range(7) == 0) digits = {"0", digits};
    for (int k = 0; k < digits.len(); k++) begin
      if ($urandom_range(9) == 0) send_byte(CH_SPACE);
      send_byte(digits[k]);
    end
    if ($urandom_range(6) == 0) send_byte(any_but_newline());
    send_byte(CH_NL);
  endtask

  // An unfinished line, left open for an end of file or an abort.
  task automatic send_partial();
    repeat ($urandom_range(3))
      send_byte($urandom_range(1) ? 8'(8'h30 + $urandom_range(9)) : any_but_newline());
  endtask

  // Mostly well-formed event text with random content, plus some noise.
  task automatic run_random(int n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        repeat (4) send_number_line();
      end else if (pick < 55) begin
        if ($urandom_range(3) == 0) send_byte(CH_SPACE);
        send_byte(CH_N);
        if ($urandom_range(3) == 0) send_byte(any_but_newline());
        send_byte(CH_NL);
      end else if (pick < 65) begin
        send_byte(CH_Q);
        send_byte(CH_NL);
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(4)) send_byte(any_but_newline());
          send_byte(CH_NL);
        end
        if ($urandom_range(1) == 1) begin
          send_byte(CH_Q);
          send_byte(CH_NL);
        end
      end else if (pick < 75) begin
        repeat ($urandom_range(5)) send_byte(any_but_newline());
        send_byte(CH_NL);
      end else if (pick < 83) begin
        send_number_line();
      end else if (pick < 88) begin
        send_partial();
        send_marker(MODE_EOF);
      end else if (pick < 92) begin
        send_partial();
        send_marker(MODE_ABORT);
      end else if (pick < 95) begin
        send_marker(MODE_UNUSED);
      end else begin
        send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Result side: random back-pressure and an in-order check of every transaction.
  always @(posedge clk) begin : result_check
    lep_res_t want;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual kind %0d",
                   $time, out_data.kind);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_data.kind);
        check_field("led_index", want.led_index, out_data.led_index);
        check_field("red", want.red, out_data.red);
        check_field("green", want.green, out_data.green);
        check_field("blue", want.blue, out_data.blue);
        check_field("records_so_far", want.records_so_far, out_data.records_so_far);
        check_field("bin_number", want.bin_number, out_data.bin_number);
        check_field("header_char", want.header_char, out_data.header_char);
        check_field("last", want.last, out_data.last);
        results_checked++;
      end
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    stim_row_t dir_rows[$];
    stim_row_t r;
    lep_res_t event_end;

    event_end = '0;
    event_end.kind = KIND_EVENT;
    event_end.last = 1'b1;

    // End of file and abort straight after reset give a bare event end;
    // the unused mode gives nothing.
    r = txt(8'h00);
    r.item.mode = MODE_EOF;
    r.typed = 1'b1;
    r.n_typed = 1;
    r.typed_res = event_end;
    dir_rows.push_back(r);
    r.item = mk_item(MODE_ABORT, 8'hFF);
    dir_rows.push_back(r);
    r.item = mk_item(MODE_UNUSED, 8'hFF);
    r.n_typed = 0;
    dir_rows.push_back(r);
    // An index that saturates.
    repeat (5) dir_rows.push_back(txt("9"));
    dir_rows.push_back(txt(CH_NL));
    // A red of 300 with a space inside keeps its low byte.
    dir_rows.push_back(txt("3"));
    dir_rows.push_back(txt(CH_SPACE));
    dir_rows.push_back(txt("0"));
    dir_rows.push_back(txt("0"));
    dir_rows.push_back(txt(CH_NL));
    dir_rows.push_back(txt("7"));
    dir_rows.push_back(txt(CH_NL));
    // A NUL ends the leading digits of the blue value.
    dir_rows.push_back(txt("9"));
    dir_rows.push_back(txt(8'h00));
    dir_rows.push_back(txt("9"));
    dir_rows.push_back(txt(CH_NL));
    // Header mode: a character, its line end, an empty line, and end of
    // file with a header line still open.
    dir_rows.push_back(txt(CH_Q));
    dir_rows.push_back(txt(CH_NL));
    dir_rows.push_back(txt(CH_N));
    dir_rows.push_back(txt(CH_NL));
    dir_rows.push_back(txt(CH_NL));
    dir_rows.push_back(txt(CH_N));
    r = txt(8'h00);
    r.item.mode = MODE_EOF;
    dir_rows.push_back(r);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].n_typed,
                dir_rows[i].typed_res);
    drain();

    // Random phases under each idling pattern and brightness limit.
    set_limit(8'd0);
    run_random(RANDOM_ITEMS);
    drain();

    set_limit(8'd255);
    send_idle_pct = 71;
    run_random(RANDOM_ITEMS);
    drain();

    set_limit(8'($urandom_range(255)));
    send_idle_pct = 0;
    recv_stall_pct = 71;
    run_random(RANDOM_ITEMS);
    drain();

    set_limit(8'($urandom_range(1, 16)));
    send_idle_pct = 12;
    recv_stall_pct = 12;
    run_random(RANDOM_ITEMS);
    drain();

    $display("Checked %0d results from %0d input transactions, %0d limit writes, %0d errors.",
             results_checked, items_sent, limit_writes, errors);
    $display("Covered header mode, clamping, index saturation, aborts and end of file.");
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #(2_000_000);
    $display("Run did not finish in time, %0d results still owed.", pending_results.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
rtl/lep_pkg.sv
rtl/lep_parser.sv
rtl/lep_out_fifo.sv
rtl/led_event_text_parser.sv
bench/tb.sv
